// ===== sv/cdq_pkg.sv =====
package cdq_pkg;

    localparam int MAX_POINTS          = 1024;
    localparam int QUARTER_TABLE_STEPS = 512;

    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int MAX_LOG2   = ADDR_W;
    localparam int MIN_LOG2   = 2;
    localparam int LOG2_W     = 4;
    localparam int SAMPLE_W   = 16;
    localparam int ROM_W      = 15;
    localparam int COS_W      = ROM_W + 2;
    localparam int PROD_W     = SAMPLE_W + COS_W;
    localparam int ACC_W      = PROD_W + ADDR_W;
    localparam int ROM_IDX_W  = $clog2(QUARTER_TABLE_STEPS + 1);
    localparam int QTR_LOG2   = $clog2(QUARTER_TABLE_STEPS);
    localparam int NUM_W      = ADDR_W + QTR_LOG2 + 1;
    localparam int FRAC_SHIFT = 15;

    localparam logic [ADDR_W:0]     POINT_ONE = (ADDR_W + 1)'(1);
    localparam logic [LOG2_W-1:0]   LOG2_RESET = LOG2_W'(10);

    // Input transaction kinds carried on tuser
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_BIN  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } cdq_state_t;

    typedef struct packed {
        logic clear;
        logic valid;
    } cdq_mac_ctrl_t;

    typedef logic [QUARTER_TABLE_STEPS:0][ROM_W-1:0] cdq_cos_rom_t;

    localparam logic [63:0] ONE_Q61      = 64'h2000_0000_0000_0000;
    localparam logic [63:0] HALF_PI_Q61  = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] HALF_PI_STEP = HALF_PI_Q61 / 64'(QUARTER_TABLE_STEPS);
    localparam logic [63:0] HALF_PI_REM  = HALF_PI_Q61 % 64'(QUARTER_TABLE_STEPS);

    // (a*b) >> 61, truncated to 64 bits
    function automatic logic [63:0] mul_q61(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[124:61];
    endfunction

    // Taylor series of cos in Q61, Horner form
    function automatic logic [63:0] cos_q61(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] f;
        logic [63:0] t;
        x2 = mul_q61(x, x);
        f  = ONE_Q61;
        for (int k = 11; k >= 1; k--) begin
            t = mul_q61(x2, f) / 64'((2 * k - 1) * (2 * k));
            f = (t >= ONE_Q61) ? 64'd0 : ONE_Q61 - t;
        end
        return f;
    endfunction

    // The step count is a power of two, so the remainder term scales by a shift
    function automatic cdq_cos_rom_t build_cos_rom();
        cdq_cos_rom_t rom;
        logic [63:0]  x;
        logic [63:0]  y;
        logic [63:0]  v;
        for (int i = 0; i <= QUARTER_TABLE_STEPS; i++) begin
            x = HALF_PI_STEP * 64'(i) + ((HALF_PI_REM * 64'(i)) >> QTR_LOG2);
            y = cos_q61(x) >> 29;
            v = (y * 64'd32767 + 64'h8000_0000) >> 32;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            rom[i] = v[ROM_W-1:0];
        end
        rom[QUARTER_TABLE_STEPS] = '0;
        return rom;
    endfunction

    localparam cdq_cos_rom_t COS_ROM = build_cos_rom();

endpackage

// ===== sv/cdq_sample_ram.sv =====
module cdq_sample_ram
    import cdq_pkg::*;
(
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic signed [SAMPLE_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic signed [SAMPLE_W-1:0] rd_data
);

    logic signed [SAMPLE_W-1:0] mem [MAX_POINTS];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/cdq_cos_lookup.sv =====
module cdq_cos_lookup
    import cdq_pkg::*;
(
    input  logic                     aclk,
    input  logic [ADDR_W-1:0]        phase,
    input  logic [LOG2_W-1:0]        log2_eff,
    output logic signed [COS_W-1:0]  cos_value
);

    logic [ADDR_W:0]         n_pts;
    logic [ADDR_W:0]         half_pts;
    logic [1:0]              quad;
    logic [ADDR_W:0]         fold;
    logic                    neg;
    logic [NUM_W-1:0]        num;
    logic [NUM_W-1:0]        idx_wide;
    logic [ROM_IDX_W-1:0]    idx;
    logic [ROM_IDX_W-1:0]    idx_reg;
    logic                    neg_reg;
    logic [ROM_W-1:0]        rom_val;
    logic signed [COS_W-1:0] cos_next;
    logic signed [COS_W-1:0] cos_reg;

    // Fold the phase into the first quadrant
    always_comb begin
        n_pts    = POINT_ONE << log2_eff;
        half_pts = n_pts >> 1;
        quad     = 2'({1'b0, phase} >> (log2_eff - LOG2_W'(2)));
        case (quad)
            2'd0: begin
                fold = {1'b0, phase};
                neg  = 1'b0;
            end
            2'd1: begin
                fold = half_pts - {1'b0, phase};
                neg  = 1'b1;
            end
            2'd2: begin
                fold = {1'b0, phase} - half_pts;
                neg  = 1'b1;
            end
            default: begin
                fold = n_pts - {1'b0, phase};
                neg  = 1'b0;
            end
        endcase
        num      = (NUM_W'(fold) << (QTR_LOG2 + 2)) + NUM_W'(half_pts);
        idx_wide = num >> log2_eff;
        if (idx_wide > NUM_W'(QUARTER_TABLE_STEPS)) begin
            idx = ROM_IDX_W'(QUARTER_TABLE_STEPS);
        end else begin
            idx = idx_wide[ROM_IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx;
        neg_reg <= neg;
    end

    always_comb begin
        rom_val  = COS_ROM[idx_reg];
        cos_next = neg_reg ? -$signed({2'b00, rom_val}) : $signed({2'b00, rom_val});
    end

    always_ff @(posedge aclk) begin
        cos_reg <= cos_next;
    end

    assign cos_value = cos_reg;

endmodule

// ===== sv/cdq_mac.sv =====
module cdq_mac
    import cdq_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cdq_mac_ctrl_t              ctrl,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [COS_W-1:0]    cos_value,
    output logic                       busy,
    output logic signed [ACC_W-1:0]    acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(sample) * PROD_W'(cos_value);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctrl.valid;
        end
    end

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.clear) begin
            acc_next = '0;
        end else if (prod_vld_reg) begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign busy = prod_vld_reg;
    assign acc  = acc_reg;

endmodule

// ===== sv/cosine_dft_quarter_wave_lut.sv =====
// Channel    | Direction | Transaction
// -----------+-----------+----------------------------------------------------
// s_axis     | in        | tuser: mode; tdata: sample_index, sample_value, bin_index
// m_axis     | out       | tdata: bin_number, bin_value
// APB        | in/out    | register 0 at byte address 0: log2_points
//
// A load writes the sample RAM straight from the input transfer. A bin request walks the n
// stored samples at one multiply-accumulate per cycle, then drains a four-stage pipeline;
// the request rate is bounded by the single read port of the sample RAM.
// Reset sets log2_points to 10; sample RAM contents are undefined until loaded.
// The result sits in an output register, so loads are taken while it waits;
// a new request is taken as soon as the previous one has left the datapath.
module cosine_dft_quarter_wave_lut
    import cdq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [9:0] sample_index, [25:10] sample_value,
                                   // [35:26] bin_index, [39:36] zero
    input  logic        s_tuser,   // [0] mode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [9:0] bin_number, [25:10] bin_value, [31:26] zero

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Input field unpacking
    logic [ADDR_W-1:0]          in_sample_index;
    logic signed [SAMPLE_W-1:0] in_sample_value;
    logic [ADDR_W-1:0]          in_bin_index;

    assign in_sample_index = s_tdata[9:0];
    assign in_sample_value = $signed(s_tdata[25:10]);
    assign in_bin_index    = s_tdata[35:26];

    // Configuration register
    logic [LOG2_W-1:0] log2_reg;
    logic [LOG2_W-1:0] log2_eff;
    logic [ADDR_W-1:0] mask;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log2_reg <= LOG2_RESET;
        end else if (cfg_wr) begin
            log2_reg <= pwdata[LOG2_W-1:0];
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? {28'd0, log2_reg} : 32'd0;

    // Clamp the point count to the supported range
    always_comb begin
        if (log2_reg < LOG2_W'(MIN_LOG2)) begin
            log2_eff = LOG2_W'(MIN_LOG2);
        end else if (log2_reg > LOG2_W'(MAX_LOG2)) begin
            log2_eff = LOG2_W'(MAX_LOG2);
        end else begin
            log2_eff = log2_reg;
        end
        mask = ADDR_W'((POINT_ONE << log2_eff) - POINT_ONE);
    end

    // Control state
    cdq_state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]          k_reg, k_next;
    logic [ADDR_W-1:0]          t_reg, t_next;
    logic [ADDR_W-1:0]          p_reg, p_next;
    logic                       v1_reg, v2_reg;
    logic signed [SAMPLE_W-1:0] samp_reg;
    logic                       out_vld_reg, out_vld_next;
    logic [ADDR_W-1:0]          out_bin_reg, out_bin_next;
    logic signed [SAMPLE_W-1:0] out_val_reg, out_val_next;

    logic                       in_take;
    logic                       ram_we;
    logic                       issue;
    logic                       pipe_busy;
    logic                       mac_busy;
    cdq_mac_ctrl_t              mac_ctrl;
    logic signed [SAMPLE_W-1:0] ram_rdata;
    logic signed [COS_W-1:0]    cos_value;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    acc_shift;
    logic signed [SAMPLE_W-1:0] bin_result;

    assign pipe_busy = v1_reg || v2_reg || mac_busy;

    // Scale by 1/(32768*n) with floor, then saturate; the shift reaches 25
    always_comb begin
        acc_shift = acc >>> ({1'b0, log2_eff} + (LOG2_W + 1)'(FRAC_SHIFT));
        if (acc_shift > ACC_W'(32767)) begin
            bin_result = 16'sh7FFF;
        end else if (acc_shift < -ACC_W'(32768)) begin
            bin_result = -16'sh8000;
        end else begin
            bin_result = acc_shift[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        t_next       = t_reg;
        p_next       = p_reg;
        out_vld_next = out_vld_reg;
        out_bin_next = out_bin_reg;
        out_val_next = out_val_reg;
        s_tready     = 1'b0;
        ram_we       = 1'b0;
        issue        = 1'b0;
        mac_ctrl     = '0;
        in_take      = 1'b0;

        // Drop the result once the consumer takes it
        if (out_vld_reg && m_tready) begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                in_take  = s_tvalid;
                if (in_take) begin
                    if (s_tuser == MODE_LOAD) begin
                        // Ignore loads past the current block length
                        ram_we = (in_sample_index & ~mask) == '0;
                    end else begin
                        k_next         = in_bin_index & mask;
                        t_next         = '0;
                        p_next         = '0;
                        mac_ctrl.clear = 1'b1;
                        state_next     = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                issue  = 1'b1;
                t_next = t_reg + ADDR_W'(1);
                p_next = (p_reg + k_reg) & mask;
                if (t_reg == mask) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // Hold until the accumulator settles and the output slot frees
                if (!pipe_busy && (!out_vld_reg || m_tready)) begin
                    out_vld_next = 1'b1;
                    out_bin_next = k_reg;
                    out_val_next = bin_result;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        mac_ctrl.valid = v2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            v1_reg      <= issue;
            v2_reg      <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg       <= k_next;
        t_reg       <= t_next;
        p_reg       <= p_next;
        out_bin_reg <= out_bin_next;
        out_val_reg <= out_val_next;
        samp_reg    <= ram_rdata;
    end

    cdq_sample_ram u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (in_sample_index),
        .wr_data (in_sample_value),
        .rd_addr (t_reg),
        .rd_data (ram_rdata)
    );

    cdq_cos_lookup u_cos (
        .aclk      (aclk),
        .phase     (p_reg),
        .log2_eff  (log2_eff),
        .cos_value (cos_value)
    );

    cdq_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (mac_ctrl),
        .sample    (samp_reg),
        .cos_value (cos_value),
        .busy      (mac_busy),
        .acc       (acc)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_val_reg, out_bin_reg};

    // A result appears only when a request completes
    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside request completion");

    // Nothing is in flight while new input is taken
    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pipe_busy)
        else $error("datapath busy while idle");

    // The sample walk stays inside the current block
    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> ((t_reg & ~mask) == '0) && ((p_reg & ~mask) == '0))
        else $error("sample walk left the block");

endmodule
